@@ rtl/sbm_pkg.sv @@
// Shared types and constants for the spectrum band level meter.
// Used by sbm_ctrl, sbm_datapath and spectrum_band_led_meter; no dependencies.
package sbm_pkg;

   localparam int unsigned BIN_W     = 7;
   localparam int unsigned MAG_W     = 20;
   localparam int unsigned BAND_W    = 3;
   localparam int unsigned LEVEL_W   = 8;
   localparam int unsigned GATE_W    = 16;
   localparam int unsigned GAIN_W    = 4;
   localparam int unsigned ATTACK_W  = 5;
   localparam int unsigned DECAY_W   = 8;
   localparam int unsigned CNT_W     = 7;
   localparam int unsigned GPROD_W   = GATE_W + CNT_W;
   localparam int unsigned GAP_PROD_W = LEVEL_W + ATTACK_W;
   localparam int unsigned STEP_W    = 3;

   localparam int unsigned NUM_BANDS = 6;
   localparam int unsigned DIV_STEPS = 8;

   localparam logic [BIN_W-1:0]  FRAME_END_BIN = 7'd127;
   localparam logic [BAND_W-1:0] LAST_BAND     = 3'd5;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 8'd255;

   // floor(x / 20) == (x * 3277) >> 16 for every x below 8192
   localparam int unsigned RECIP_W     = 12;
   localparam int unsigned RECIP_SHIFT = 16;
   localparam logic [RECIP_W-1:0] RECIP_20 = 12'd3277;

   localparam logic [BIN_W-1:0] BAND_LO [NUM_BANDS] = '{7'd0, 7'd1, 7'd4, 7'd8, 7'd32, 7'd64};
   localparam logic [BIN_W-1:0] BAND_HI [NUM_BANDS] = '{7'd1, 7'd4, 7'd8, 7'd32, 7'd64, 7'd127};
   localparam logic [CNT_W-1:0] BAND_COUNT [NUM_BANDS] =
      '{7'd2, 7'd4, 7'd5, 7'd25, 7'd33, 7'd64};

   // Register file
   localparam int unsigned CSR_IDX_W  = 4;
   localparam int unsigned CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_GATE  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_SHIFT  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK      = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_STEP  = 4'd3;

   localparam logic [GATE_W-1:0]   NOISE_GATE_RST = 16'd50;
   localparam logic [GAIN_W-1:0]   GAIN_SHIFT_RST = 4'd2;
   localparam logic [ATTACK_W-1:0] ATTACK_RST     = 5'd13;
   localparam logic [DECAY_W-1:0]  DECAY_STEP_RST = 8'd3;

   typedef struct packed {
      logic [BIN_W-1:0] bin_index;
      logic [MAG_W-1:0] magnitude;
   } req_type;

   typedef struct packed {
      logic [BAND_W-1:0]  band;
      logic [LEVEL_W-1:0] brightness;
      logic               last_band;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_CHECK,
      ST_DIV,
      ST_MUL,
      ST_OUT
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic              accum;
      logic              load;
      logic              check;
      logic              div_step;
      logic              mul;
      logic              out;
      logic [BAND_W-1:0] band;
      logic              last;
   } cmd_type;

endpackage

@@ rtl/sbm_ctrl.sv @@
// Controller for the spectrum band level meter: accepts bins, sequences the
// per-band frame-end work. Depends on sbm_pkg.
module sbm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  sbm_pkg::req_type  req_item,
   output logic              busy,
   output sbm_pkg::cmd_type  cmd
);

   sbm_pkg::state_type state_ff, state_in;
   logic [sbm_pkg::BAND_W-1:0] band_ff, band_in;
   logic [sbm_pkg::STEP_W-1:0] step_ff, step_in;

   assign busy = (state_ff != sbm_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sbm_pkg::ST_IDLE;
         band_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         band_ff  <= band_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      band_in      = band_ff;
      step_in      = step_ff;
      cmd          = '0;
      cmd.band     = band_ff;
      cmd.last     = (band_ff == sbm_pkg::LAST_BAND);
      unique case (state_ff)
         sbm_pkg::ST_IDLE: begin
            cmd.accum = start;
            if (start && req_item.bin_index == sbm_pkg::FRAME_END_BIN) begin
               band_in  = '0;
               state_in = sbm_pkg::ST_LOAD;
            end
         end
         sbm_pkg::ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = sbm_pkg::ST_CHECK;
         end
         sbm_pkg::ST_CHECK: begin
            cmd.check = 1'b1;
            step_in   = '0;
            state_in  = sbm_pkg::ST_DIV;
         end
         sbm_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == sbm_pkg::STEP_W'(sbm_pkg::DIV_STEPS - 1)) begin
               state_in = sbm_pkg::ST_MUL;
            end
         end
         sbm_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = sbm_pkg::ST_OUT;
         end
         sbm_pkg::ST_OUT: begin
            cmd.out = 1'b1;
            if (band_ff == sbm_pkg::LAST_BAND) begin
               state_in = sbm_pkg::ST_IDLE;
            end else begin
               band_in  = band_ff + 1'b1;
               state_in = sbm_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = sbm_pkg::ST_IDLE;
         end
      endcase
   end

   a_frame_end_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.bin_index == sbm_pkg::FRAME_END_BIN) |=> busy)
      else $error("frame end bin did not start band processing");

   a_last_band_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.out && cmd.last) |=> !busy)
      else $error("controller stayed busy after the last band");

   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sbm_pkg::ST_DIV && step_ff == sbm_pkg::STEP_W'(sbm_pkg::DIV_STEPS - 1))
      |=> state_ff == sbm_pkg::ST_MUL)
      else $error("divide sequence did not end after its last step");

endmodule

@@ rtl/sbm_datapath.sv @@
// Datapath for the spectrum band level meter: band sums, register file,
// restoring divider, smoothing and result register. Depends on sbm_pkg.
module sbm_datapath #(
   parameter int unsigned MAG_BITS = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sbm_pkg::cmd_type                  cmd,
   input  sbm_pkg::req_type                  req_item,
   input  logic                              csr_valid,
   input  logic [sbm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sbm_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic                              rsp_valid,
   output sbm_pkg::rsp_type                  rsp_item
);

   localparam int unsigned SUM_BITS = MAG_BITS + 6;
   // room for the widest sum and for the divisor shifted up by the step count
   localparam int unsigned DIV_W    = SUM_BITS + 24;
   localparam int unsigned MAG_USE  = (MAG_BITS < sbm_pkg::MAG_W) ? MAG_BITS : sbm_pkg::MAG_W;
   localparam int unsigned RISE_W   = sbm_pkg::GAP_PROD_W + sbm_pkg::RECIP_W;

   // Register file
   logic [sbm_pkg::GATE_W-1:0]   gate_ff;
   logic [sbm_pkg::GAIN_W-1:0]   gain_ff;
   logic [sbm_pkg::ATTACK_W-1:0] attack_ff;
   logic [sbm_pkg::DECAY_W-1:0]  decay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff   <= sbm_pkg::NOISE_GATE_RST;
         gain_ff   <= sbm_pkg::GAIN_SHIFT_RST;
         attack_ff <= sbm_pkg::ATTACK_RST;
         decay_ff  <= sbm_pkg::DECAY_STEP_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            sbm_pkg::CSR_NOISE_GATE: gate_ff   <= csr_wdata[sbm_pkg::GATE_W-1:0];
            sbm_pkg::CSR_GAIN_SHIFT: gain_ff   <= csr_wdata[sbm_pkg::GAIN_W-1:0];
            sbm_pkg::CSR_ATTACK:     attack_ff <= csr_wdata[sbm_pkg::ATTACK_W-1:0];
            sbm_pkg::CSR_DECAY_STEP: decay_ff  <= csr_wdata[sbm_pkg::DECAY_W-1:0];
            default: ;
         endcase
      end
   end

   // Band accumulators, one saturating adder per band
   logic [SUM_BITS-1:0] sum_ff [sbm_pkg::NUM_BANDS];
   logic [SUM_BITS-1:0] sum_in [sbm_pkg::NUM_BANDS];
   logic [SUM_BITS-1:0] mag_ext;
   logic [SUM_BITS:0]   add_w  [sbm_pkg::NUM_BANDS];

   assign mag_ext = SUM_BITS'(req_item.magnitude[MAG_USE-1:0]);

   always_comb begin
      for (int b = 0; b < sbm_pkg::NUM_BANDS; b++) begin
         add_w[b]  = {1'b0, sum_ff[b]} + {1'b0, mag_ext};
         sum_in[b] = sum_ff[b];
         if (cmd.accum && req_item.bin_index >= sbm_pkg::BAND_LO[b]
             && req_item.bin_index <= sbm_pkg::BAND_HI[b]) begin
            sum_in[b] = add_w[b][SUM_BITS] ? '1 : add_w[b][SUM_BITS-1:0];
         end
         // drop all sums once the last band is out
         if (cmd.out && cmd.last) begin
            sum_in[b] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < sbm_pkg::NUM_BANDS; b++) begin
            sum_ff[b] <= '0;
         end
      end else begin
         for (int b = 0; b < sbm_pkg::NUM_BANDS; b++) begin
            sum_ff[b] <= sum_in[b];
         end
      end
   end

   // Gate check and restoring divide: target = floor(sum / (count << gain))
   logic [DIV_W-1:0]             rem_ff;
   logic [DIV_W-1:0]             dsh_ff;
   logic [sbm_pkg::GPROD_W-1:0]  gprod_ff;
   logic [sbm_pkg::LEVEL_W-1:0]  quo_ff;
   logic                         zero_ff;
   logic                         sat_ff;
   logic [sbm_pkg::CNT_W-1:0]    count_w;
   logic                         fits_w;

   assign count_w = sbm_pkg::BAND_COUNT[cmd.band];
   assign fits_w  = (rem_ff >= dsh_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rem_ff   <= DIV_W'(sum_ff[cmd.band]);
         dsh_ff   <= (DIV_W'(count_w) << gain_ff) << sbm_pkg::DIV_STEPS;
         gprod_ff <= sbm_pkg::GPROD_W'(gate_ff) * sbm_pkg::GPROD_W'(count_w);
      end else if (cmd.check) begin
         zero_ff <= (rem_ff < DIV_W'(gprod_ff));
         // quotient of 256 or more clamps to full scale
         sat_ff  <= fits_w;
         dsh_ff  <= dsh_ff >> 1;
         quo_ff  <= '0;
      end else if (cmd.div_step) begin
         if (fits_w) begin
            rem_ff <= rem_ff - dsh_ff;
         end
         quo_ff <= {quo_ff[sbm_pkg::LEVEL_W-2:0], fits_w};
         dsh_ff <= dsh_ff >> 1;
      end
   end

   // Smoothing toward the target
   logic [sbm_pkg::LEVEL_W-1:0]    level_ff [sbm_pkg::NUM_BANDS];
   logic [sbm_pkg::LEVEL_W-1:0]    tgt_in;
   logic [sbm_pkg::LEVEL_W-1:0]    cur_rd;
   logic [sbm_pkg::LEVEL_W-1:0]    tgt_ff;
   logic [sbm_pkg::LEVEL_W-1:0]    cur_ff;
   logic [sbm_pkg::GAP_PROD_W-1:0] prod_ff;
   logic [sbm_pkg::GAP_PROD_W-1:0] prod_in;
   logic [RISE_W-1:0]              rise_w;
   logic [sbm_pkg::LEVEL_W+1:0]    up_w;
   logic [sbm_pkg::LEVEL_W-1:0]    level_in;

   assign cur_rd = level_ff[cmd.band];

   always_comb begin
      if (zero_ff) begin
         tgt_in = '0;
      end else if (sat_ff) begin
         tgt_in = sbm_pkg::LEVEL_MAX;
      end else begin
         tgt_in = quo_ff;
      end
      prod_in = '0;
      if (tgt_in > cur_rd) begin
         prod_in = sbm_pkg::GAP_PROD_W'(tgt_in - cur_rd)
                 * sbm_pkg::GAP_PROD_W'(attack_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         tgt_ff  <= tgt_in;
         cur_ff  <= cur_rd;
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      rise_w = RISE_W'(prod_ff) * RISE_W'(sbm_pkg::RECIP_20);
      up_w   = (sbm_pkg::LEVEL_W+2)'(cur_ff)
             + (sbm_pkg::LEVEL_W+2)'(rise_w[RISE_W-1:sbm_pkg::RECIP_SHIFT]);
      if (tgt_ff > cur_ff) begin
         // cap the rise at the target when attack exceeds twenty
         level_in = (up_w > (sbm_pkg::LEVEL_W+2)'(tgt_ff)) ? tgt_ff
                                                          : up_w[sbm_pkg::LEVEL_W-1:0];
      end else if (cur_ff > tgt_ff) begin
         level_in = (cur_ff > decay_ff) ? cur_ff - decay_ff : '0;
      end else begin
         level_in = cur_ff;
      end
   end

   logic             rsp_valid_ff;
   sbm_pkg::rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < sbm_pkg::NUM_BANDS; b++) begin
            level_ff[b] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out) begin
            level_ff[cmd.band] <= level_in;
         end
         rsp_valid_ff <= cmd.out;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out) begin
         rsp_ff.band       <= cmd.band;
         rsp_ff.brightness <= level_in;
         rsp_ff.last_band  <= cmd.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.last_band) |-> rsp_ff.band == sbm_pkg::LAST_BAND)
      else $error("last_band set on a band other than the last");

   a_sums_cleared: assert property (@(posedge clock) disable iff (reset)
      (cmd.out && cmd.last) |=> (sum_ff[0] == '0 && sum_ff[5] == '0))
      else $error("band sums not cleared at frame end");

endmodule

@@ rtl/spectrum_band_led_meter.sv @@
// Top level of the spectrum band level meter.
// Instantiates sbm_ctrl and sbm_datapath; types from sbm_pkg.
//
//   channel   ports                          handshake
//   -------   ----------------------------   -----------------------------------
//   request   start, busy, req_item          taken when start && !busy
//   result    rsp_valid, rsp_item            one cycle per result, no back-pressure
//   config    csr_valid, csr_ready,          written when csr_valid && csr_ready
//             csr_index, csr_wdata
//
// Bins 0..126 are taken one per cycle while busy is low. Bin 127 adds in, then
// busy stays high while each band in turn goes through load, gate check, 8 steps
// of the shared restoring divider, the attack multiply and write-back, giving one
// result per band. Reset is synchronous; it clears sums and levels and loads the
// register defaults. The result side cannot stall; csr_ready is always high.
module spectrum_band_led_meter #(
   parameter int unsigned MAG_BITS = 20
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  sbm_pkg::req_type                req_item,
   output logic                            rsp_valid,
   output sbm_pkg::rsp_type                rsp_item,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sbm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sbm_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   sbm_pkg::cmd_type cmd;

   assign csr_ready = 1'b1;

   sbm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .busy     (busy),
      .cmd      (cmd)
   );

   sbm_datapath #(
      .MAG_BITS (MAG_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_item  (req_item),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for spectrum_band_led_meter: streams frames of spectrum bins,
// predicts the six band levels closing each frame and checks every result.
// Depends on sbm_pkg and the meter RTL.
module tb;

   localparam int unsigned SUM_W = sbm_pkg::MAG_W + 6;
   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
   localparam logic [sbm_pkg::MAG_W-1:0] MAG_FULL = {sbm_pkg::MAG_W{1'b1}};
   localparam logic [sbm_pkg::BIN_W-1:0] BIN_CLOSE = 7'd127;
   localparam int unsigned ATTACK_DEN = 20;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned RANDOM_ITEMS = 270;
   localparam int unsigned RANDOM_FRAMES = 8;
   localparam int unsigned SETTLE_CYCLES = 100;
   localparam logic [sbm_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 4'd4;
   localparam logic [sbm_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 4'd15;

   typedef enum {FRAME_FULL, FRAME_SPARSE, FRAME_NOISE, FRAME_STUCK, FRAME_EMPTY} frame_kind_type;
   typedef enum {MAG_QUIET, MAG_LOW, MAG_MID, MAG_EDGE, MAG_ANY} mag_range_type;

   typedef struct packed {
      sbm_pkg::req_type item;
      logic [1:0]       hold;
   } pending_type;

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   sbm_pkg::req_type req_item = '0;
   logic rsp_valid;
   sbm_pkg::rsp_type rsp_item;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [sbm_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [sbm_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state and register copies
   int unsigned band_lo [sbm_pkg::NUM_BANDS] = '{0, 1, 4, 8, 32, 64};
   int unsigned band_hi [sbm_pkg::NUM_BANDS] = '{1, 4, 8, 32, 64, 127};
   logic [SUM_W-1:0] band_sum [sbm_pkg::NUM_BANDS];
   logic [sbm_pkg::LEVEL_W-1:0] band_level [sbm_pkg::NUM_BANDS];
   logic [sbm_pkg::GATE_W-1:0] gate_cfg = 16'd50;
   logic [sbm_pkg::GAIN_W-1:0] shift_cfg = 4'd2;
   logic [sbm_pkg::ATTACK_W-1:0] attack_cfg = 5'd13;
   logic [sbm_pkg::DECAY_W-1:0] decay_cfg = 8'd3;

   pending_type bin_queue [$];
   sbm_pkg::rsp_type level_queue [$];
   pending_type head_bin;
   sbm_pkg::rsp_type want;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned items_queued = 0;
   int unsigned frames_queued = 0;

   spectrum_band_led_meter DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Add one bin into its bands; on the closing bin compute the six new levels.
   function automatic void accumulate_bin(input sbm_pkg::req_type r);
      logic [SUM_W:0] grown;
      logic [SUM_W-1:0] gate_floor;
      logic [SUM_W-1:0] divisor;
      logic [SUM_W-1:0] quotient;
      logic [sbm_pkg::CNT_W-1:0] count;
      logic [sbm_pkg::LEVEL_W-1:0] target;
      logic [sbm_pkg::LEVEL_W-1:0] cur;
      logic [sbm_pkg::LEVEL_W+sbm_pkg::ATTACK_W-1:0] scaled_gap;
      logic [sbm_pkg::LEVEL_W+1:0] raised;
      sbm_pkg::rsp_type res;
      for (int b = 0; b < sbm_pkg::NUM_BANDS; b++) begin
         if (r.bin_index >= band_lo[b] && r.bin_index <= band_hi[b]) begin
            grown = (SUM_W+1)'(band_sum[b]) + (SUM_W+1)'(r.magnitude);
            band_sum[b] = (grown > SUM_MAX) ? SUM_MAX : grown[SUM_W-1:0];
         end
      end
      if (r.bin_index != BIN_CLOSE)
         return;
      for (int b = 0; b < sbm_pkg::NUM_BANDS; b++) begin
         count = sbm_pkg::CNT_W'(band_hi[b] - band_lo[b] + 1);
         gate_floor = SUM_W'(gate_cfg) * SUM_W'(count);
         if (band_sum[b] < gate_floor) begin
            target = '0;
         end else begin
            divisor = SUM_W'(count);
            divisor = divisor << shift_cfg;
            quotient = band_sum[b] / divisor;
            target = (quotient > 255) ? 8'd255 : quotient[sbm_pkg::LEVEL_W-1:0];
         end
         cur = band_level[b];
         if (cur < target) begin
            scaled_gap = (sbm_pkg::LEVEL_W+sbm_pkg::ATTACK_W)'(target - cur)
                       * (sbm_pkg::LEVEL_W+sbm_pkg::ATTACK_W)'(attack_cfg);
            raised = (sbm_pkg::LEVEL_W+2)'(cur + scaled_gap / ATTACK_DEN);
            // attack above twenty would overshoot: cap at the target
            band_level[b] = (raised > target) ? target : raised[sbm_pkg::LEVEL_W-1:0];
         end else if (cur > target) begin
            band_level[b] = (cur > decay_cfg) ? cur - decay_cfg : '0;
         end
         band_sum[b] = '0;
         res.band = sbm_pkg::BAND_W'(b);
         res.brightness = band_level[b];
         res.last_band = (b == sbm_pkg::NUM_BANDS - 1);
         level_queue.push_back(res);
      end
   endfunction

   // Driver: present queued bins, holding each for its drawn gap first.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_item <= '0;
      end else begin
         if (start && !busy)
            accumulate_bin(req_item);
         if (!(start && busy)) begin
            if (bin_queue.size() != 0) begin
               head_bin = bin_queue.pop_front();
               if (head_bin.hold != 0) begin
                  head_bin.hold = head_bin.hold - 2'd1;
                  bin_queue.push_front(head_bin);
                  start <= 1'b0;
               end else begin
                  req_item <= head_bin.item;
                  start <= 1'b1;
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobed result must match the oldest predicted level.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (level_queue.size() == 0) begin
            $display("%0t: unexpected result band %0d brightness %0d last_band %0b",
                     $time, rsp_item.band, rsp_item.brightness, rsp_item.last_band);
            mismatch_count++;
         end else begin
            want = level_queue.pop_front();
            if (rsp_item.band !== want.band) begin
               $display("%0t: band expected %0d actual %0d", $time, want.band, rsp_item.band);
               mismatch_count++;
            end
            if (rsp_item.brightness !== want.brightness) begin
               $display("%0t: band %0d brightness expected %0d actual %0d", $time,
                        want.band, want.brightness, rsp_item.brightness);
               mismatch_count++;
            end
            if (rsp_item.last_band !== want.last_band) begin
               $display("%0t: band %0d last_band expected %0b actual %0b", $time,
                        want.band, want.last_band, rsp_item.last_band);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic write_reg(input logic [sbm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [sbm_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         sbm_pkg::CSR_NOISE_GATE: gate_cfg = data[sbm_pkg::GATE_W-1:0];
         sbm_pkg::CSR_GAIN_SHIFT: shift_cfg = data[sbm_pkg::GAIN_W-1:0];
         sbm_pkg::CSR_ATTACK:     attack_cfg = data[sbm_pkg::ATTACK_W-1:0];
         sbm_pkg::CSR_DECAY_STEP: decay_cfg = data[sbm_pkg::DECAY_W-1:0];
         default: ;
      endcase
   endtask

   // Called at the falling edge only, so the driver never races the queue.
   task automatic queue_bin(input logic [sbm_pkg::BIN_W-1:0] bin,
                            input logic [sbm_pkg::MAG_W-1:0] mag,
                            input int unsigned gap_max);
      pending_type p;
      p.item.bin_index = bin;
      p.item.magnitude = mag;
      p.hold = 2'($urandom_range(0, gap_max));
      bin_queue.push_back(p);
      items_queued++;
   endtask

   function automatic logic [sbm_pkg::MAG_W-1:0] draw_magnitude(input mag_range_type span);
      case (span)
         MAG_QUIET: return sbm_pkg::MAG_W'($urandom_range(0, 255));
         MAG_LOW:   return sbm_pkg::MAG_W'($urandom_range(0, 4095));
         MAG_MID:   return sbm_pkg::MAG_W'($urandom_range(0, 65535));
         MAG_EDGE:  return $urandom_range(0, 1) ? MAG_FULL : '0;
         default:   return sbm_pkg::MAG_W'($urandom);
      endcase
   endfunction

   task automatic queue_random_frame();
      int unsigned roll;
      int unsigned gap_max;
      int unsigned bin;
      int unsigned reps;
      frame_kind_type kind;
      mag_range_type span;
      roll = $urandom_range(0, 9);
      kind = (roll == 0) ? FRAME_FULL : (roll <= 4) ? FRAME_SPARSE :
             (roll == 5) ? FRAME_NOISE : (roll == 6) ? FRAME_STUCK :
             (roll == 7) ? FRAME_EMPTY : FRAME_SPARSE;
      span = mag_range_type'($urandom_range(0, 4));
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : 3;
      case (kind)
         FRAME_FULL: begin
            for (bin = 0; bin < 127; bin++)
               queue_bin(sbm_pkg::BIN_W'(bin), draw_magnitude(span), gap_max);
         end
         FRAME_SPARSE: begin
            bin = $urandom_range(0, 6);
            while (bin < 127) begin
               queue_bin(sbm_pkg::BIN_W'(bin), draw_magnitude(span), gap_max);
               bin += $urandom_range(1, 12);
            end
         end
         FRAME_NOISE: begin
            // any order, repeats, and a stray closing bin may end the frame early
            reps = $urandom_range(1, 20);
            repeat (reps) queue_bin(sbm_pkg::BIN_W'($urandom_range(0, 127)),
                                    sbm_pkg::MAG_W'($urandom), gap_max);
         end
         FRAME_STUCK: begin
            // a stuck bin at full scale drives its bands into saturation
            bin = $urandom_range(0, 126);
            reps = $urandom_range(66, 80);
            repeat (reps) queue_bin(sbm_pkg::BIN_W'(bin), MAG_FULL, gap_max);
         end
         default: ;
      endcase
      queue_bin(BIN_CLOSE, draw_magnitude(span), gap_max);
      frames_queued++;
   endtask

   task automatic write_random_config();
      if ($urandom_range(0, 1))
         write_reg(sbm_pkg::CSR_NOISE_GATE, $urandom_range(0, 3) == 0 ? 16'hFFFF :
                   $urandom_range(0, 2) == 0 ? 16'h0000 :
                   sbm_pkg::CSR_DATA_W'($urandom_range(0, 600)));
      if ($urandom_range(0, 1))
         write_reg(sbm_pkg::CSR_GAIN_SHIFT, $urandom_range(0, 1) ?
                   sbm_pkg::CSR_DATA_W'($urandom) :
                   sbm_pkg::CSR_DATA_W'($urandom_range(0, 4)));
      if ($urandom_range(0, 1))
         write_reg(sbm_pkg::CSR_ATTACK, $urandom_range(0, 1) ?
                   sbm_pkg::CSR_DATA_W'($urandom) :
                   sbm_pkg::CSR_DATA_W'($urandom_range(0, 20)));
      if ($urandom_range(0, 1))
         write_reg(sbm_pkg::CSR_DECAY_STEP, $urandom_range(0, 1) ?
                   sbm_pkg::CSR_DATA_W'($urandom) :
                   sbm_pkg::CSR_DATA_W'($urandom_range(0, 8)));
      if ($urandom_range(0, 3) == 0)
         write_reg(sbm_pkg::CSR_IDX_W'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI)),
                   sbm_pkg::CSR_DATA_W'($urandom));
   endtask

   // Wait until every queued bin is taken and every level has come back.
   task automatic drain();
      do @(negedge clock);
      while (bin_queue.size() != 0 || start || level_queue.size() != 0);
      repeat (16) @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   initial begin
      for (int b = 0; b < sbm_pkg::NUM_BANDS; b++) begin
         band_sum[b] = '0;
         band_level[b] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default registers: overlapping bins at full scale, repeated bin, empty frame
      queue_bin(7'd0, MAG_FULL, 0);
      queue_bin(7'd1, MAG_FULL, 0);
      queue_bin(7'd4, MAG_FULL, 0);
      queue_bin(7'd8, '0, 0);
      queue_bin(7'd32, MAG_FULL, 0);
      queue_bin(7'd64, MAG_FULL, 0);
      queue_bin(BIN_CLOSE, MAG_FULL, 0);
      repeat (3) queue_bin(7'd0, sbm_pkg::MAG_W'(5), 3);
      queue_bin(BIN_CLOSE, '0, 3);
      queue_bin(BIN_CLOSE, '0, 1);
      drain();

      // no gate, no shift, attack above twenty, largest decay; high data bits dropped
      write_reg(sbm_pkg::CSR_NOISE_GATE, 16'h0000);
      write_reg(sbm_pkg::CSR_GAIN_SHIFT, 16'hFFF0);
      write_reg(sbm_pkg::CSR_ATTACK, 16'hFFFF);
      write_reg(sbm_pkg::CSR_DECAY_STEP, 16'hFFFF);
      write_reg(CSR_SPARE_HI, 16'hFFFF);
      @(negedge clock);
      queue_bin(7'd0, MAG_FULL, 2);
      queue_bin(BIN_CLOSE, MAG_FULL, 2);
      queue_bin(BIN_CLOSE, '0, 2);
      queue_bin(7'd1, sbm_pkg::MAG_W'(1), 0);
      queue_bin(7'd126, sbm_pkg::MAG_W'(3), 0);
      queue_bin(BIN_CLOSE, sbm_pkg::MAG_W'(2), 0);
      drain();

      // highest gate and shift, no attack, no decay
      write_reg(sbm_pkg::CSR_NOISE_GATE, 16'hFFFF);
      write_reg(sbm_pkg::CSR_GAIN_SHIFT, 16'h000F);
      write_reg(sbm_pkg::CSR_ATTACK, 16'h0000);
      write_reg(sbm_pkg::CSR_DECAY_STEP, 16'h0000);
      @(negedge clock);
      queue_bin(7'd64, MAG_FULL, 1);
      queue_bin(BIN_CLOSE, MAG_FULL, 1);
      drain();

      items_queued = 0;
      frames_queued = 0;
      while (items_queued < RANDOM_ITEMS || frames_queued < RANDOM_FRAMES) begin
         write_random_config();
         @(negedge clock);
         repeat ($urandom_range(1, 3)) queue_random_frame();
         drain();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && level_queue.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
